// ===== rtl/core/mlpfi_pkg.sv =====
package mlpfi_pkg;

    localparam int NODES     = 16;
    localparam int NODE_W    = 4;
    localparam int FRAC      = 12;
    localparam int ACC_W     = 38;
    localparam int WADDR_W   = 10;
    localparam int WDEPTH    = 768;
    localparam logic signed [15:0] ONE = 16'sd4096;
    localparam logic [15:0] TANH_TOP = 16'd65492;

    localparam logic [1:0] CMD_WEIGHT = 2'd0;
    localparam logic [1:0] CMD_INPUT  = 2'd1;
    localparam logic [1:0] CMD_EVAL   = 2'd2;

    localparam logic [1:0] ACT_IDENT = 2'd0;
    localparam logic [1:0] ACT_STEP  = 2'd1;
    localparam logic [1:0] ACT_TANH  = 2'd2;

    localparam logic [2:0] REG_NUM_LAYERS = 3'd0;
    localparam logic [2:0] REG_SIZE0      = 3'd1;
    localparam logic [2:0] REG_SIZE1      = 3'd2;
    localparam logic [2:0] REG_SIZE2      = 3'd3;
    localparam logic [2:0] REG_SIZE3      = 3'd4;
    localparam logic [2:0] REG_ACT1       = 3'd5;
    localparam logic [2:0] REG_ACT2       = 3'd6;
    localparam logic [2:0] REG_ACT3       = 3'd7;

    typedef struct packed {
        logic               wt_we;
        logic               wt_clear;
        logic [WADDR_W-1:0] wt_waddr;
        logic               in_we;
        logic [NODE_W-1:0]  in_addr;
        logic               mac_issue;
        logic [WADDR_W-1:0] rd_addr;
        logic               prev_inputs;
        logic               prev_bank;
        logic [NODE_W-1:0]  rd_branch;
        logic               acc_clr;
        logic               round_en;
        logic               sat_clr;
        logic [1:0]         act;
        logic               lv_we;
        logic               lv_bank;
        logic [NODE_W-1:0]  lv_node;
        logic               res_en;
        logic               out_load;
        logic               out_zero;
    } mlpfi_cmd_t;

    function automatic logic [15:0] tanh_tab(input logic [5:0] k);
        logic [15:0] v;
        case (k)
            6'd0:  v = 16'd0;     6'd1:  v = 16'd8150;  6'd2:  v = 16'd16051;
            6'd3:  v = 16'd23485; 6'd4:  v = 16'd30285; 6'd5:  v = 16'd36358;
            6'd6:  v = 16'd41625; 6'd7:  v = 16'd46145; 6'd8:  v = 16'd49912;
            6'd9:  v = 16'd53038; 6'd10: v = 16'd55593; 6'd11: v = 16'd57660;
            6'd12: v = 16'd59320; 6'd13: v = 16'd60643; 6'd14: v = 16'd61694;
            6'd15: v = 16'd62524; 6'd16: v = 16'd63179; 6'd17: v = 16'd63693;
            6'd18: v = 16'd64096; 6'd19: v = 16'd64412; 6'd20: v = 16'd64659;
            6'd21: v = 16'd64852; 6'd22: v = 16'd65003; 6'd23: v = 16'd65120;
            6'd24: v = 16'd65212; 6'd25: v = 16'd65283; 6'd26: v = 16'd65339;
            6'd27: v = 16'd65383; 6'd28: v = 16'd65417; 6'd29: v = 16'd65443;
            6'd30: v = 16'd65464; 6'd31: v = 16'd65480;
            default: v = TANH_TOP;
        endcase
        return v;
    endfunction

    function automatic logic [4:0] clamp_size(input logic [4:0] s);
        logic [4:0] r;
        r = s;
        if (s == 5'd0) r = 5'd1;
        else if (s > 5'(NODES)) r = 5'(NODES);
        return r;
    endfunction

endpackage

// ===== rtl/core/mlp_forward_inference.sv =====
// Channel  Ports           Beat contents
// s_       tvalid/tready   tuser: cmd; tdata: layer_index, node_index, branch_index,
//                          data_value
// m_       tvalid/tready   tdata: node_result; tuser: saturated
// cfg_     we/addr/wdata   register write, no handshake
//
// An evaluate beat is paced, for each computed node, by its fan-in through the single
// shared multiply-accumulate and the weight RAM read port.
// After reset the weight RAM is swept to 1.0 over all 768 words with s_tready low.
// A finished result waits in the controller, with s_tready low, until the m_ side has
// taken the previous one.
module mlp_forward_inference (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // layer_index, node_index, branch_index, data_value
    input  logic [1:0]  s_tuser,  // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // node_result
    output logic [0:0]  m_tuser   // saturated
);

    mlpfi_pkg::mlpfi_cmd_t cmd;
    logic signed [15:0]    node_result;
    logic                  saturated;

    mlpfi_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .cmd_code     (s_tuser),
        .layer_index  (s_tdata[1:0]),
        .node_index   (s_tdata[5:2]),
        .branch_index (s_tdata[9:6]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .cmd          (cmd)
    );

    mlpfi_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .data_value  ($signed(s_tdata[25:10])),
        .node_result (node_result),
        .saturated   (saturated)
    );

    assign m_tdata    = node_result;
    assign m_tuser[0] = saturated;

endmodule

// ===== rtl/core/mlpfi_ram.sv =====
module mlpfi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 768
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/mlpfi_dp.sv =====
module mlpfi_dp (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  mlpfi_pkg::mlpfi_cmd_t   cmd,
    input  logic signed [15:0]      data_value,
    output logic signed [15:0]      node_result,
    output logic                    saturated
);

    logic signed [15:0] in_mem [mlpfi_pkg::NODES];
    logic signed [15:0] lv_mem [2][mlpfi_pkg::NODES];
    logic [15:0]        wt_q;
    logic signed [15:0] prev_reg, prev_next;
    logic               v1_reg, v2_reg;
    logic signed [31:0] prod_reg;
    logic signed [mlpfi_pkg::ACC_W-1:0] acc_reg, rv;
    logic               hi, lo;
    logic signed [15:0] rnd_val, rnd_reg;
    logic               sat_reg;
    logic signed [16:0] xs;
    logic [16:0]        mag;
    logic               t_neg_reg, t_big_reg;
    logic [15:0]        t_y0_reg, t_diff_reg;
    logic [8:0]         t_frac_reg;
    logic [24:0]        t_prod_reg;
    logic [16:0]        ty, tr;
    logic signed [15:0] tanh_val, act_val, res_reg;

    mlpfi_ram #(.WIDTH(16), .DEPTH(mlpfi_pkg::WDEPTH)) u_wt (
        .aclk  (aclk),
        .we    (cmd.wt_we),
        .waddr (cmd.wt_waddr),
        .wdata (cmd.wt_clear ? mlpfi_pkg::ONE : data_value),
        .raddr (cmd.rd_addr),
        .rdata (wt_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < mlpfi_pkg::NODES; i++) begin
                in_mem[i] <= '0;
            end
        end else if (cmd.in_we) begin
            in_mem[cmd.in_addr] <= data_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.lv_we) begin
            lv_mem[cmd.lv_bank][cmd.lv_node] <= act_val;
        end
    end

    assign prev_next = cmd.prev_inputs ? in_mem[cmd.rd_branch]
                                       : lv_mem[cmd.prev_bank][cmd.rd_branch];

    always_comb begin
        rv      = acc_reg + mlpfi_pkg::ACC_W'(1 << (mlpfi_pkg::FRAC - 1));
        hi      = rv >= (mlpfi_pkg::ACC_W'(1) <<< (mlpfi_pkg::FRAC + 15));
        lo      = rv < -(mlpfi_pkg::ACC_W'(1) <<< (mlpfi_pkg::FRAC + 15));
        rnd_val = hi ? 16'sh7fff : lo ? 16'sh8000
                : rv[mlpfi_pkg::FRAC+15:mlpfi_pkg::FRAC];
    end

    always_comb begin
        xs       = {rnd_reg[15], rnd_reg};
        mag      = rnd_reg[15] ? 17'(-xs) : 17'(xs);
        ty       = t_big_reg ? {1'b0, mlpfi_pkg::TANH_TOP}
                 : {1'b0, t_y0_reg} + {1'b0, t_prod_reg[24:9]};
        tr       = (ty + 17'd8) >> 4;
        tanh_val = t_neg_reg ? -$signed(tr[15:0]) : $signed(tr[15:0]);
        case (cmd.act)
            mlpfi_pkg::ACT_STEP: act_val = rnd_reg[15] ? 16'sd0 : mlpfi_pkg::ONE;
            mlpfi_pkg::ACT_TANH: act_val = tanh_val;
            default:             act_val = rnd_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            sat_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.mac_issue;
            v2_reg <= v1_reg;
            if (cmd.sat_clr) begin
                sat_reg <= 1'b0;
            end else if (cmd.round_en && (hi || lo)) begin
                sat_reg <= 1'b1;
            end
        end
        prev_reg <= prev_next;
        prod_reg <= $signed(wt_q) * prev_reg;
        if (cmd.acc_clr) begin
            acc_reg <= '0;
        end else if (v2_reg) begin
            acc_reg <= acc_reg + mlpfi_pkg::ACC_W'(prod_reg);
        end
        if (cmd.round_en) begin
            rnd_reg <= rnd_val;
        end
        t_neg_reg  <= rnd_reg[15];
        t_big_reg  <= mag[16:9] >= 8'd32;
        t_y0_reg   <= mlpfi_pkg::tanh_tab({1'b0, mag[13:9]});
        t_diff_reg <= mlpfi_pkg::tanh_tab(6'({1'b0, mag[13:9]}) + 6'd1)
                    - mlpfi_pkg::tanh_tab({1'b0, mag[13:9]});
        t_frac_reg <= mag[8:0];
        t_prod_reg <= t_diff_reg * t_frac_reg;
        if (cmd.res_en) begin
            res_reg <= act_val;
        end
        if (cmd.out_load) begin
            node_result <= cmd.out_zero ? 16'sd0 : res_reg;
            saturated   <= cmd.out_zero ? 1'b0 : sat_reg;
        end
    end

endmodule

// ===== rtl/core/mlpfi_ctrl.sv =====
module mlpfi_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_addr,
    input  logic [4:0]            cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            cmd_code,
    input  logic [1:0]            layer_index,
    input  logic [3:0]            node_index,
    input  logic [3:0]            branch_index,
    output logic                  out_valid,
    input  logic                  out_ready,
    output mlpfi_pkg::mlpfi_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MAC, S_DRAIN1, S_DRAIN2, S_ROUND,
        S_ACT1, S_ACT2, S_WRITE, S_OUT
    } state_t;

    state_t      state_reg;
    logic [9:0]  clr_reg;
    logic [1:0]  layer_reg, last_reg;
    logic [3:0]  node_reg, br_reg, tgt_reg;
    logic [4:0]  np_reg;
    logic        bank_reg, zero_reg;
    logic [2:0]  nl_reg;
    logic [4:0]  size_reg [4];
    logic [1:0]  act_reg [1:3];
    logic        acc_in, out_free;
    logic [2:0]  nlc;
    logic [1:0]  last_next;

    function automatic logic [4:0] size_of(input logic [1:0] l, input logic [4:0] s [4]);
        return mlpfi_pkg::clamp_size(s[l]);
    endfunction

    assign in_ready = state_reg == S_IDLE;
    assign acc_in   = in_valid && in_ready;
    assign out_free = !out_valid || out_ready;
    assign nlc      = (nl_reg < 3'd2) ? 3'd2 : (nl_reg > 3'd4) ? 3'd4 : nl_reg;
    assign last_next = 2'(nlc - 3'd1);

    always_comb begin
        cmd             = '0;
        cmd.wt_clear    = state_reg == S_CLEAR;
        cmd.wt_we       = cmd.wt_clear ||
                          (acc_in && cmd_code == mlpfi_pkg::CMD_WEIGHT && layer_index != 2'd0);
        cmd.wt_waddr    = cmd.wt_clear ? clr_reg
                        : {2'(layer_index - 2'd1), node_index, branch_index};
        cmd.in_we       = acc_in && cmd_code == mlpfi_pkg::CMD_INPUT;
        cmd.in_addr     = node_index;
        cmd.mac_issue   = state_reg == S_MAC;
        cmd.rd_addr     = {2'(layer_reg - 2'd1), node_reg, br_reg};
        cmd.prev_inputs = layer_reg == 2'd1;
        cmd.prev_bank   = !bank_reg;
        cmd.rd_branch   = br_reg;
        cmd.acc_clr     = state_reg == S_MAC && br_reg == 4'd0;
        cmd.round_en    = state_reg == S_ROUND;
        cmd.sat_clr     = acc_in && cmd_code == mlpfi_pkg::CMD_EVAL;
        cmd.act         = (layer_reg == 2'd0) ? mlpfi_pkg::ACT_IDENT : act_reg[layer_reg];
        cmd.lv_we       = state_reg == S_WRITE && layer_reg != last_reg;
        cmd.res_en      = state_reg == S_WRITE && layer_reg == last_reg;
        cmd.lv_bank     = bank_reg;
        cmd.lv_node     = node_reg;
        cmd.out_load    = state_reg == S_OUT && out_free;
        cmd.out_zero    = zero_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            out_valid <= 1'b0;
            nl_reg    <= 3'd3;
            for (int i = 0; i < 4; i++) begin
                size_reg[i] <= 5'd16;
            end
            for (int i = 1; i < 4; i++) begin
                act_reg[i] <= mlpfi_pkg::ACT_IDENT;
            end
            layer_reg <= 2'd1;
            last_reg  <= 2'd2;
            node_reg  <= '0;
            br_reg    <= '0;
            tgt_reg   <= '0;
            np_reg    <= 5'd1;
            bank_reg  <= 1'b0;
            zero_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    mlpfi_pkg::REG_NUM_LAYERS: nl_reg      <= cfg_wdata[2:0];
                    mlpfi_pkg::REG_SIZE0:      size_reg[0] <= cfg_wdata;
                    mlpfi_pkg::REG_SIZE1:      size_reg[1] <= cfg_wdata;
                    mlpfi_pkg::REG_SIZE2:      size_reg[2] <= cfg_wdata;
                    mlpfi_pkg::REG_SIZE3:      size_reg[3] <= cfg_wdata;
                    mlpfi_pkg::REG_ACT1:       act_reg[1]  <= cfg_wdata[1:0];
                    mlpfi_pkg::REG_ACT2:       act_reg[2]  <= cfg_wdata[1:0];
                    mlpfi_pkg::REG_ACT3:       act_reg[3]  <= cfg_wdata[1:0];
                    default: ;
                endcase
            end
            if (cmd.out_load) begin
                out_valid <= 1'b1;
            end else if (out_ready) begin
                out_valid <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 10'd1;
                    if (clr_reg == 10'(mlpfi_pkg::WDEPTH - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (acc_in && cmd_code == mlpfi_pkg::CMD_EVAL) begin
                        tgt_reg  <= node_index;
                        last_reg <= last_next;
                        if ({1'b0, node_index} >= size_of(last_next, size_reg)) begin
                            zero_reg  <= 1'b1;
                            state_reg <= S_OUT;
                        end else begin
                            zero_reg  <= 1'b0;
                            layer_reg <= 2'd1;
                            bank_reg  <= 1'b0;
                            np_reg    <= size_of(2'd0, size_reg);
                            br_reg    <= '0;
                            node_reg  <= (last_next == 2'd1) ? node_index : 4'd0;
                            state_reg <= S_MAC;
                        end
                    end
                end
                S_MAC: begin
                    br_reg <= br_reg + 4'd1;
                    if ({1'b0, br_reg} == np_reg - 5'd1) begin
                        br_reg    <= '0;
                        state_reg <= S_DRAIN1;
                    end
                end
                S_DRAIN1: state_reg <= S_DRAIN2;
                S_DRAIN2: state_reg <= S_ROUND;
                S_ROUND:  state_reg <= S_ACT1;
                S_ACT1:   state_reg <= S_ACT2;
                S_ACT2:   state_reg <= S_WRITE;
                S_WRITE: begin
                    if (layer_reg == last_reg) begin
                        state_reg <= S_OUT;
                    end else if ({1'b0, node_reg} == size_of(layer_reg, size_reg) - 5'd1) begin
                        layer_reg <= layer_reg + 2'd1;
                        np_reg    <= size_of(layer_reg, size_reg);
                        bank_reg  <= !bank_reg;
                        node_reg  <= (2'(layer_reg + 2'd1) == last_reg) ? tgt_reg : 4'd0;
                        state_reg <= S_MAC;
                    end else begin
                        node_reg  <= node_reg + 4'd1;
                        state_reg <= S_MAC;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== verif/tb_mlp_forward_inference.sv =====
`timescale 1ns / 1ps

module tb_mlp_forward_inference;

    typedef struct {
        logic signed [15:0] value;
        logic               sat;
    } node_result_t;

    class mlp_scoreboard;
        logic signed [15:0] weights [768];
        logic signed [15:0] net_inputs [16];
        logic [4:0]         sizes [4];
        logic [1:0]         acts [4];
        logic [2:0]         layers_reg;
        int                 lv [2][16];
        node_result_t       pending_results [$];
        int                 errors;
        int                 n_evals;
        int                 n_writes;
        int                 n_results;
        int unsigned        tanh_lut [33];

        function new();
            tanh_lut = '{0, 8150, 16051, 23485, 30285, 36358, 41625, 46145,
                         49912, 53038, 55593, 57660, 59320, 60643, 61694, 62524,
                         63179, 63693, 64096, 64412, 64659, 64852, 65003, 65120,
                         65212, 65283, 65339, 65383, 65417, 65443, 65464, 65480,
                         65492};
            foreach (weights[i]) weights[i] = mlpfi_pkg::ONE;
            foreach (net_inputs[i]) net_inputs[i] = '0;
            layers_reg = 3'd3;
            for (int i = 0; i < 4; i++) begin
                sizes[i] = 5'd16;
                acts[i] = mlpfi_pkg::ACT_IDENT;
            end
        endfunction

        function void set_reg(logic [2:0] idx, logic [4:0] val);
            if (idx == mlpfi_pkg::REG_NUM_LAYERS) layers_reg = val[2:0];
            else if (idx <= mlpfi_pkg::REG_SIZE3) sizes[idx - mlpfi_pkg::REG_SIZE0] = val;
            else acts[idx - mlpfi_pkg::REG_SIZE3] = val[1:0];
        endfunction

        function int eff_size(int l);
            int s;
            s = sizes[l];
            if (s < 1) s = 1;
            if (s > 16) s = 16;
            return s;
        endfunction

        function int eff_layers();
            int n;
            n = layers_reg;
            if (n < 2) n = 2;
            if (n > 4) n = 4;
            return n;
        endfunction

        function int round_saturate(longint acc, inout bit sat);
            longint v;
            longint lim;
            v = acc + 2048;
            lim = longint'(32768) << mlpfi_pkg::FRAC;
            if (v >= lim) begin
                sat = 1;
                return 32767;
            end
            if (v < -lim) begin
                sat = 1;
                return -32768;
            end
            return int'(v >>> mlpfi_pkg::FRAC);
        endfunction

        function int tanh_q(int x);
            int unsigned a, seg, frac, y;
            int r;
            a = (x < 0) ? -x : x;
            seg = a >> 9;
            frac = a & 511;
            if (seg >= 32) y = tanh_lut[32];
            else y = tanh_lut[seg] + (((tanh_lut[seg+1] - tanh_lut[seg]) * frac) >> 9);
            r = int'((y + 8) >> 4);
            return (x < 0) ? -r : r;
        endfunction

        function int eval_node(int l, int node, int pb, int np, inout bit sat);
            longint acc;
            int s;
            acc = 0;
            for (int b = 0; b < np; b++)
                acc += longint'(weights[((l - 1) * 16 + node) * 16 + b]) * longint'(lv[pb][b]);
            s = round_saturate(acc, sat);
            case (acts[l])
                mlpfi_pkg::ACT_STEP: return (s >= 0) ? 4096 : 0;
                mlpfi_pkg::ACT_TANH: return tanh_q(s);
                default:             return s;
            endcase
        endfunction

        function void note_beat(logic [1:0] cmd, logic [31:0] data);
            logic [1:0]         lyr;
            logic [3:0]         node, branch;
            logic signed [15:0] val;
            int                 last, np, pb, n;
            bit                 sat;
            node_result_t       r;
            lyr = data[1:0];
            node = data[5:2];
            branch = data[9:6];
            val = data[25:10];
            case (cmd)
                mlpfi_pkg::CMD_WEIGHT: begin
                    n_writes++;
                    if (lyr != 0) weights[((lyr - 1) * 16 + node) * 16 + branch] = val;
                end
                mlpfi_pkg::CMD_INPUT: begin
                    n_writes++;
                    net_inputs[node] = val;
                end
                mlpfi_pkg::CMD_EVAL: begin
                    n_evals++;
                    sat = 0;
                    last = eff_layers() - 1;
                    np = eff_size(0);
                    pb = 0;
                    for (int j = 0; j < np; j++) lv[0][j] = net_inputs[j];
                    for (int l = 1; l < last; l++) begin
                        n = eff_size(l);
                        for (int j = 0; j < n; j++)
                            lv[1-pb][j] = eval_node(l, j, pb, np, sat);
                        pb = 1 - pb;
                        np = n;
                    end
                    if (node < eff_size(last)) begin
                        r.value = 16'(eval_node(last, node, pb, np, sat));
                        r.sat = sat;
                    end else begin
                        r.value = '0;
                        r.sat = 0;
                    end
                    pending_results.push_back(r);
                end
                default: ;
            endcase
        endfunction

        function void check_beat(logic [15:0] res, logic sat);
            node_result_t e;
            n_results++;
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: node_result %0d", $signed(res));
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (res !== e.value) begin
                $error("node_result: expected %0d, got %0d", e.value, $signed(res));
                errors++;
            end
            if (sat !== e.sat) begin
                $error("saturated: expected %0d, got %0d", e.sat, sat);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [4:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;

    mlp_scoreboard sb;
    int            send_idle_pct;
    int            recv_idle_pct;

    mlp_forward_inference dut (.*);

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_beat(s_tuser, s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check_beat(m_tdata, m_tuser[0]);
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_beat(logic [1:0] cmd, logic [1:0] lyr, logic [3:0] node,
                             logic [3:0] branch, logic [15:0] val);
        if ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3)) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'd0, val, branch, node, lyr};
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (800) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [4:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        sb.set_reg(idx, val);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] rand_value();
        if ($urandom_range(1)) return 16'($urandom_range(8191)) - 16'd4096;
        return 16'($urandom);
    endfunction

    task automatic random_beats(int count);
        int done, r;
        done = 0;
        while (done < count) begin
            r = $urandom_range(99);
            if (r < 40) begin
                send_beat(mlpfi_pkg::CMD_WEIGHT, 2'($urandom_range(3, 1)), 4'($urandom),
                          4'($urandom), rand_value());
                done++;
            end else if (r < 60) begin
                send_beat(mlpfi_pkg::CMD_INPUT, 2'($urandom), 4'($urandom), 4'($urandom),
                          rand_value());
                done++;
            end else if (r < 85) begin
                send_beat(mlpfi_pkg::CMD_EVAL, 2'($urandom), 4'($urandom_range(3)),
                          4'($urandom), 16'($urandom));
                done++;
            end else if (r < 92) begin
                send_beat(mlpfi_pkg::CMD_EVAL, 2'($urandom), 4'($urandom), 4'($urandom),
                          16'($urandom));
                done++;
            end else if (r < 96) begin
                send_beat(2'd3, 2'($urandom), 4'($urandom), 4'($urandom), 16'($urandom));
                done++;
            end else begin
                send_beat(mlpfi_pkg::CMD_WEIGHT, 2'd0, 4'($urandom), 4'($urandom),
                          16'($urandom));
                done++;
            end
        end
    endtask

    task automatic apply_config(int phase);
        logic [4:0] nl, s0, s1, s2, s3, a1, a2, a3;
        case (phase)
            1: begin
                nl = 2; s0 = 1; s1 = 1; s2 = 1; s3 = 1;
                a1 = 5'(mlpfi_pkg::ACT_IDENT);
                a2 = 5'(mlpfi_pkg::ACT_IDENT);
                a3 = 5'(mlpfi_pkg::ACT_IDENT);
            end
            2: begin
                nl = 4; s0 = 16; s1 = 16; s2 = 16; s3 = 16;
                a1 = 5'(mlpfi_pkg::ACT_TANH);
                a2 = 5'(mlpfi_pkg::ACT_TANH);
                a3 = 5'(mlpfi_pkg::ACT_TANH);
            end
            3: begin
                nl = 4; s0 = 3; s1 = 5; s2 = 2; s3 = 4;
                a1 = 5'(mlpfi_pkg::ACT_STEP);
                a2 = 5'(mlpfi_pkg::ACT_STEP);
                a3 = 5'(mlpfi_pkg::ACT_STEP);
            end
            4: begin
                nl = 0; s0 = 0; s1 = 31; s2 = 0; s3 = 17;
                a1 = 3; a2 = 3; a3 = 3;
            end
            5: begin
                nl = 7; s0 = 2; s1 = 3; s2 = 3; s3 = 2;
                a1 = 5'(mlpfi_pkg::ACT_TANH);
                a2 = 5'(mlpfi_pkg::ACT_STEP);
                a3 = 5'(mlpfi_pkg::ACT_IDENT);
            end
            default: begin
                nl = ($urandom_range(9) == 0) ? 5'($urandom_range(7)) : 5'($urandom_range(4, 2));
                s0 = 5'($urandom_range(6, 1));
                s1 = 5'($urandom_range(6, 1));
                s2 = 5'($urandom_range(6, 1));
                s3 = ($urandom_range(7) == 0) ? 5'($urandom) : 5'($urandom_range(4, 1));
                a1 = 5'($urandom_range(3));
                a2 = 5'($urandom_range(3));
                a3 = 5'($urandom_range(3));
            end
        endcase
        write_reg(mlpfi_pkg::REG_NUM_LAYERS, nl);
        write_reg(mlpfi_pkg::REG_SIZE0, s0);
        write_reg(mlpfi_pkg::REG_SIZE1, s1);
        write_reg(mlpfi_pkg::REG_SIZE2, s2);
        write_reg(mlpfi_pkg::REG_SIZE3, s3);
        write_reg(mlpfi_pkg::REG_ACT1, a1);
        write_reg(mlpfi_pkg::REG_ACT2, a2);
        write_reg(mlpfi_pkg::REG_ACT3, a3);
    endtask

    initial begin
        #20_000_000;
        $display("FAIL mlp_forward_inference");
        $finish;
    end

    initial begin
        sb = new();
        send_idle_pct = 23;
        recv_idle_pct = 57;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset state: zero inputs, all weights 1.0
        send_beat(mlpfi_pkg::CMD_EVAL, 2'd0, 4'd0, 4'd0, 16'd0);
        send_beat(mlpfi_pkg::CMD_INPUT, 2'd0, 4'd0, 4'd0, 16'h7fff);
        send_beat(mlpfi_pkg::CMD_INPUT, 2'd0, 4'd15, 4'd0, 16'h8000);
        send_beat(mlpfi_pkg::CMD_EVAL, 2'd0, 4'd15, 4'd0, 16'd0);
        send_beat(mlpfi_pkg::CMD_INPUT, 2'd0, 4'd15, 4'd0, 16'h7fff);
        send_beat(mlpfi_pkg::CMD_EVAL, 2'd0, 4'd3, 4'd0, 16'd0);
        send_beat(mlpfi_pkg::CMD_WEIGHT, 2'd1, 4'd15, 4'd15, 16'h8000);
        send_beat(mlpfi_pkg::CMD_WEIGHT, 2'd2, 4'd0, 4'd0, 16'h7fff);
        send_beat(mlpfi_pkg::CMD_WEIGHT, 2'd3, 4'd7, 4'd9, 16'h0000);
        send_beat(mlpfi_pkg::CMD_WEIGHT, 2'd0, 4'd1, 4'd1, 16'h1234);
        send_beat(2'd3, 2'd3, 4'd15, 4'd15, 16'hffff);
        send_beat(mlpfi_pkg::CMD_INPUT, 2'd0, 4'd0, 4'd0, 16'h0000);
        send_beat(mlpfi_pkg::CMD_INPUT, 2'd0, 4'd15, 4'd0, 16'h0001);
        send_beat(mlpfi_pkg::CMD_EVAL, 2'd0, 4'd0, 4'd0, 16'd0);
        send_beat(mlpfi_pkg::CMD_EVAL, 2'd0, 4'd15, 4'd0, 16'd0);

        for (int phase = 1; phase <= 13; phase++) begin
            if (phase == 5) begin
                send_idle_pct = 57;
                recv_idle_pct = 23;
            end else if (phase == 10) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_idle();
            apply_config(phase);
            if (phase == 1) begin
                // beyond the one-node output layer, then its only node
                send_beat(mlpfi_pkg::CMD_EVAL, 2'd0, 4'd1, 4'd0, 16'd0);
                send_beat(mlpfi_pkg::CMD_EVAL, 2'd0, 4'd15, 4'd0, 16'd0);
                send_beat(mlpfi_pkg::CMD_EVAL, 2'd0, 4'd0, 4'd0, 16'd0);
            end
            random_beats(60);
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (800) @(posedge aclk);

        $display("Covered %0d evaluations and %0d weight/input writes over 14 configurations,",
                 sb.n_evals, sb.n_writes);
        $display("%0d result beats checked, with sender and receiver stalls in three mixes.",
                 sb.n_results);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("PASS mlp_forward_inference");
        end else begin
            $display("FAIL mlp_forward_inference");
        end
        $finish;
    end

endmodule

// ===== mlp_forward_inference.f =====
rtl/core/mlpfi_pkg.sv
rtl/core/mlpfi_ram.sv
rtl/core/mlpfi_dp.sv
rtl/core/mlpfi_ctrl.sv
rtl/core/mlp_forward_inference.sv
verif/tb_mlp_forward_inference.sv
